/* sv/brpl_pkg.sv */
// Shared types and constants for the block RMS and peak level meter.
package brpl_pkg;

    // Block length limit; samples beyond it are dropped
    localparam int unsigned MAX_BLOCK = 4096;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SQ_W     = 31;   // 32768^2 fits in 31 bits
    localparam int unsigned SUM_W    = 43;
    localparam int unsigned CNT_W    = 13;
    localparam int unsigned MEAN_W   = 32;   // even width for the root unit
    localparam int unsigned ROOT_W   = 16;
    localparam int unsigned PROD_W   = 32;

    // 1/0.707 in Q1.15
    localparam logic [ROOT_W-1:0]   RMS_SCALE  = 16'd46349;
    localparam logic [SAMPLE_W:0]   FULL_SCALE = 17'd32768;
    localparam logic [CNT_W-1:0]    MAX_COUNT  = CNT_W'(MAX_BLOCK);

    // Totals of one finished block, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] peak;
        logic [CNT_W-1:0]    count;
    } blk_sum_t;

endpackage

/* sv/block_rms_peak_level_meter_unit.sv */
// Block RMS and peak level meter: one level per audio block of one channel.
// Throughput: one sample per cycle unless a block end meets a full queue;
//   a block end occupies the back end (43-step divider, 16-step square root,
//   multiply, output), which sets the shortest block length at full rate;
//   two finished blocks can queue.
// Reset: asynchronous, active low; clears accumulators, queue and sequencer.
module block_rms_peak_level_meter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] level
);
    import brpl_pkg::*;

    logic     push;
    blk_sum_t push_data;
    logic     q_full;
    logic     q_pop;
    blk_sum_t q_data;
    logic     q_empty;

    brpl_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    brpl_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    brpl_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_level (m_axis_tdata)
    );

endmodule

/* sv/brpl_front.sv */
// Front end: sample magnitude, squaring and per-block accumulation.
module brpl_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [brpl_pkg::SAMPLE_W-1:0]     in_sample,
    input  logic                              in_last,
    output logic                              push,
    output brpl_pkg::blk_sum_t                push_data,
    input  logic                              q_full
);
    import brpl_pkg::*;

    logic                  a_valid_reg;
    logic                  a_last_reg;
    logic [SAMPLE_W-1:0]   a_mag_reg;
    logic [SQ_W-1:0]       a_sq_reg;

    logic [SUM_W-1:0]      sum_reg;
    logic [SAMPLE_W-1:0]   peak_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic [SAMPLE_W-1:0]   mag;
    logic [2*SAMPLE_W-1:0] sq_full;
    logic                  b_take;
    logic                  a_adv;
    logic                  take;
    logic [SUM_W-1:0]      sum_next;
    logic [SAMPLE_W-1:0]   peak_next;
    logic [CNT_W-1:0]      cnt_next;

    // Magnitude; the most negative sample maps to 32768
    assign mag     = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
    assign sq_full = mag * mag;

    // Accumulator stage consumes a stage A item unless a block end meets a full queue
    assign b_take   = a_valid_reg && !(a_last_reg && q_full);
    assign a_adv    = !a_valid_reg || b_take;
    assign in_ready = a_adv;

    // Updated totals, samples beyond the block limit are dropped
    always_comb
    begin
        take      = (cnt_reg < MAX_COUNT);
        sum_next  = sum_reg;
        peak_next = peak_reg;
        cnt_next  = cnt_reg;
        if (take)
        begin
            sum_next  = sum_reg + SUM_W'(a_sq_reg);
            peak_next = (a_mag_reg > peak_reg) ? a_mag_reg : peak_reg;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    assign push            = b_take && a_last_reg;
    assign push_data.sum   = sum_next;
    assign push_data.peak  = peak_next;
    assign push_data.count = cnt_next;

    // Stage A: magnitude and square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_valid)
        begin
            a_last_reg <= in_last;
            a_mag_reg  <= mag;
            a_sq_reg   <= sq_full[SQ_W-1:0];
        end
    end

    // Stage B: block totals, cleared when a block is handed off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            peak_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (b_take)
        begin
            if (a_last_reg)
            begin
                sum_reg  <= '0;
                peak_reg <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                peak_reg <= peak_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule

/* sv/brpl_queue.sv */
// Two-entry queue of finished block totals between front and back.
module brpl_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  brpl_pkg::blk_sum_t wr_data,
    output logic               full,
    input  logic               rd_en,
    output brpl_pkg::blk_sum_t rd_data,
    output logic               empty
);
    import brpl_pkg::*;

    blk_sum_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({wr_en && !full, rd_en && !empty})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

/* sv/brpl_back.sv */
// Back end: bit-serial divide, digit-serial square root, scaling and output register.
module brpl_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  brpl_pkg::blk_sum_t            q_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [brpl_pkg::SAMPLE_W-1:0] out_level
);
    import brpl_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SQRT = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [5:0]          step_reg;
    logic [SUM_W-1:0]    quo_reg;       // dividend shifts out, quotient shifts in
    logic [CNT_W-1:0]    div_reg;
    logic [CNT_W-1:0]    drem_reg;
    logic [MEAN_W-1:0]   op_reg;
    logic [ROOT_W:0]     srem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_level_reg;

    logic [CNT_W:0]      drem_sh;
    logic                dge;
    logic [CNT_W:0]      drem_sub;
    logic [ROOT_W+2:0]   srem_sh;
    logic [ROOT_W+2:0]   trial;
    logic                sge;
    logic [ROOT_W+2:0]   srem_sub;
    logic [SAMPLE_W:0]   norm;
    logic [SAMPLE_W:0]   lvl_max;
    logic [SAMPLE_W:0]   lvl_sat;
    logic                out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;

    // One restoring divide step
    always_comb
    begin
        drem_sh  = {drem_reg, quo_reg[SUM_W-1]};
        dge      = (drem_sh >= {1'b0, div_reg});
        drem_sub = drem_sh - {1'b0, div_reg};
    end

    // One square root digit
    always_comb
    begin
        srem_sh  = {srem_reg, op_reg[MEAN_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        sge      = (srem_sh >= trial);
        srem_sub = srem_sh - trial;
    end

    // Scaled RMS against peak, clamped to full scale
    always_comb
    begin
        norm    = prod_reg[PROD_W-1 -: (SAMPLE_W+1)];
        lvl_max = (norm > {1'b0, peak_reg}) ? norm : {1'b0, peak_reg};
        lvl_sat = (lvl_max > FULL_SCALE) ? FULL_SCALE : lvl_max;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_DIV;
            ST_DIV:  if (step_reg == 6'(SUM_W-1)) state_next = ST_SQRT;
            ST_SQRT: if (step_reg == 6'(ROOT_W-1)) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                step_reg <= '0;
                quo_reg  <= q_data.sum;
                div_reg  <= q_data.count;
                drem_reg <= '0;
                peak_reg <= q_data.peak;
            end
            ST_DIV:
            begin
                quo_reg  <= {quo_reg[SUM_W-2:0], dge};
                drem_reg <= dge ? drem_sub[CNT_W-1:0] : drem_sh[CNT_W-1:0];
                if (step_reg == 6'(SUM_W-1))
                begin
                    step_reg <= '0;
                    op_reg   <= {quo_reg[MEAN_W-2:0], dge};
                    srem_reg <= '0;
                    root_reg <= '0;
                end
                else
                begin
                    step_reg <= step_reg + 6'd1;
                end
            end
            ST_SQRT:
            begin
                op_reg   <= {op_reg[MEAN_W-3:0], 2'b00};
                srem_reg <= sge ? srem_sub[ROOT_W:0] : srem_sh[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], sge};
                step_reg <= step_reg + 6'd1;
            end
            ST_MUL:
            begin
                prod_reg <= root_reg * RMS_SCALE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_level_reg <= lvl_sat[SAMPLE_W-1:0];
                end
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

endmodule
